@@ rtl/core/rhcc_pkg.sv @@
`default_nettype none

package rhcc_pkg;

  // Default number of fraction bits in the cosine table.
  localparam int COS_FRAC_BITS_DEF = 30;

  // Cosine table: one entry per whole degree, 0 to 180.
  localparam int TAB_N = 181;
  // Squared table entries for up to 40 fraction bits.
  localparam int TSQ_W = 81;

  // Pi in Q2.62.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // Configuration register indexes.
  localparam logic [2:0] REG_HUE_MIN   = 3'd0;
  localparam logic [2:0] REG_HUE_MAX   = 3'd1;
  localparam logic [2:0] REG_SAT_MIN   = 3'd2;
  localparam logic [2:0] REG_SAT_MAX   = 3'd3;
  localparam logic [2:0] REG_LEVEL_MIN = 3'd4;
  localparam logic [2:0] REG_LEVEL_MAX = 3'd5;

  typedef logic [TSQ_W-1:0] tsq_arr_t [TAB_N];
  typedef logic [1:0]       tsg_arr_t [TAB_N];

  // Per-pixel working set carried down the pipeline.
  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [9:0]  sum;
    logic [7:0]  mn;
    logic [7:0]  mx;
    logic [10:0] n;        // 2r-g-b, two's complement
    logic        bleg;     // blue <= green
    logic [17:0] d;
    logic [17:0] nsq;
    logic        gray;
    logic        hue0;     // hue is forced to zero
    logic [16:0] rem;
    logic [6:0]  sq;
    logic [16:0] xlev;
    logic [6:0]  lev;
    logic [7:0]  cnt;
    logic        prb;      // current probe lies inside the table
    logic [1:0]  tsg;      // {positive, negative} of the probed entry
    logic        in_range;
    logic [8:0]  hue;
  } pix_t;

  // Q62 product, truncated.
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // Cosine of k degrees in Q62 by Taylor series.
  function automatic logic [63:0] cos_q62(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] kk;
    kk = 64'(k);
    x = (PI_Q62 / 64'd180) * kk + ((PI_Q62 % 64'd180) * kk) / 64'd180;
    x2 = mul_q62(x, x);
    term = 64'd1 << 62;
    acc = 64'd1 << 62;
    for (int n = 1; n <= 12; n++) begin
      term = mul_q62(term, x2) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc[63]) acc = 64'd0;
    return acc;
  endfunction

  // Magnitude of the rounded table entry for degree k.
  function automatic logic [63:0] tab_mag(int k, int f);
    logic [63:0] acc;
    int kk;
    kk = (k <= 90) ? k : 180 - k;
    acc = cos_q62(kk);
    return (acc + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

  // Squares of the table entries.
  function automatic tsq_arr_t build_tsq(int f);
    tsq_arr_t t;
    logic [63:0]  v;
    logic [127:0] s;
    for (int k = 0; k < TAB_N; k++) begin
      v = tab_mag(k, f);
      s = 128'(v) * 128'(v);
      t[k] = s[TSQ_W-1:0];
    end
    return t;
  endfunction

  // Signs of the table entries; degree 90 and above are stored negated.
  function automatic tsg_arr_t build_tsg(int f);
    tsg_arr_t t;
    logic nz;
    for (int k = 0; k < TAB_N; k++) begin
      nz = (tab_mag(k, f) != 64'd0);
      t[k] = {(k < 90) && nz, (k >= 90) && nz};
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rgb_to_hsi_color_range_classifier.sv @@
`default_nettype none

// RGB to HSI color range classifier.
// Input stream: one RGB pixel per transfer on in_tdata. Result stream: one
// item per pixel on out_tdata with hue in degrees, saturation and intensity
// in percent, and a mask bit that is set when all three lie inside the
// inclusive limits held in six configuration registers.
// The cfg port writes a register when cfg_we is high outside reset; an
// index above five is ignored. Write only while no pixel is in flight.
// Each pixel passes the input stage, the second stage, the search steps
// and the output stage. Throughput is one pixel per cycle while out_tready
// does not stall it. The hue search takes eight binary search steps
// over the 181-entry cosine table, each a multiply and a compare stage;
// saturation gets one quotient bit per multiply stage in the first seven.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// register defaults. When the receiver holds out_tready low, stages fill
// up behind the output register and in_tready drops only once every stage
// holds a pixel; nothing is dropped or repeated.

module rgb_to_hsi_color_range_classifier #(
  parameter int COS_FRAC_BITS = rhcc_pkg::COS_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // in_range[0], hue_deg[9:1], sat_pct[16:10],
                                       // level_pct[23:17]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [8:0]  cfg_wdata
);

  localparam int NST   = 19;
  localparam int NSTEP = 8;
  localparam int TSW   = 2 * COS_FRAC_BITS + 1;
  localparam int PW    = TSW + 20;
  localparam rhcc_pkg::tsq_arr_t TSQ = rhcc_pkg::build_tsq(COS_FRAC_BITS);
  localparam rhcc_pkg::tsg_arr_t TSG = rhcc_pkg::build_tsg(COS_FRAC_BITS);

  // Configuration registers.
  logic [8:0] hue_min_r, hue_max_r;
  logic [6:0] sat_min_r, sat_max_r, level_min_r, level_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_min_r   <= 9'd0;
      hue_max_r   <= 9'd180;
      sat_min_r   <= 7'd0;
      sat_max_r   <= 7'd100;
      level_min_r <= 7'd1;
      level_max_r <= 7'd45;
    end else if (cfg_we) begin
      case (cfg_addr)
        rhcc_pkg::REG_HUE_MIN:   hue_min_r   <= cfg_wdata;
        rhcc_pkg::REG_HUE_MAX:   hue_max_r   <= cfg_wdata;
        rhcc_pkg::REG_SAT_MIN:   sat_min_r   <= cfg_wdata[6:0];
        rhcc_pkg::REG_SAT_MAX:   sat_max_r   <= cfg_wdata[6:0];
        rhcc_pkg::REG_LEVEL_MIN: level_min_r <= cfg_wdata[6:0];
        rhcc_pkg::REG_LEVEL_MAX: level_max_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Input stage: sum, extremes and the hue numerator.
  function automatic rhcc_pkg::pix_t f_s0(logic [23:0] dat);
    rhcc_pkg::pix_t p;
    p = '0;
    p.r = dat[7:0];
    p.g = dat[15:8];
    p.b = dat[23:16];
    p.sum = 10'(p.r) + 10'(p.g) + 10'(p.b);
    p.mn = p.r;
    p.mx = p.r;
    if (p.g < p.mn) p.mn = p.g;
    if (p.b < p.mn) p.mn = p.b;
    if (p.g > p.mx) p.mx = p.g;
    if (p.b > p.mx) p.mx = p.b;
    p.n = {2'b00, p.r, 1'b0} - 11'(p.g) - 11'(p.b);
    p.bleg = (p.b <= p.g);
    return p;
  endfunction

  // Second stage: hue denominator, square of numerator, division setup
  // and the first estimate of intensity by reciprocal multiply.
  function automatic rhcc_pkg::pix_t f_s1(rhcc_pkg::pix_t pi);
    rhcc_pkg::pix_t p;
    logic [9:0]  na;
    logic [9:0]  diff;
    logic [16:0] dh;
    logic [31:0] lq;
    p = pi;
    na = p.n[10] ? 10'(-p.n) : p.n[9:0];
    p.nsq = 18'(na) * 18'(na);
    p.d = 18'(p.r) * 18'(p.r) + 18'(p.g) * 18'(p.g) + 18'(p.b) * 18'(p.b)
        - 18'(p.r) * 18'(p.g) - 18'(p.r) * 18'(p.b) - 18'(p.g) * 18'(p.b);
    p.gray = (p.mx == p.mn);
    diff = p.sum - 10'(3 * 10'(p.mn));
    dh = 17'(diff) * 17'd100;
    p.hue0 = p.gray || !(dh > 17'(p.sum));
    p.rem = dh;
    p.sq = 7'd0;
    p.xlev = 17'(p.sum) * 17'd100;
    // floor(2^24 / 765) times 100
    lq = 32'(p.sum) * 32'd2193100;
    p.lev = lq[30:24];
    p.cnt = 8'd0;
    return p;
  endfunction

  // Probe index of search step j.
  function automatic logic [8:0] f_idx(rhcc_pkg::pix_t p, int j);
    return 9'(p.cnt) + (9'd1 << (NSTEP - 1 - j)) - 9'd1;
  endfunction

  // Multiply stage of search step j, with one quotient bit of saturation on
  // steps zero to six and, on the first step, the intensity correction.
  function automatic rhcc_pkg::pix_t f_a(rhcc_pkg::pix_t pi, int j);
    rhcc_pkg::pix_t p;
    logic [8:0]  idx;
    logic [16:0] dv;
    logic [16:0] lr;
    p = pi;
    idx = f_idx(p, j);
    p.prb = (idx <= 9'd180);
    p.tsg = p.prb ? TSG[idx[7:0]] : 2'b00;
    if (j < 7) begin
      dv = 17'(p.sum) << (6 - j);
      if (p.rem >= dv) begin
        p.rem = p.rem - dv;
        p.sq[6 - j] = 1'b1;
      end
    end
    if (j == 0) begin
      lr = p.xlev - 17'(17'(p.lev) * 17'd765);
      if (lr >= 17'd765) p.lev = p.lev + 7'd1;
    end
    return p;
  endfunction

  function automatic logic [PW-1:0] f_prod(rhcc_pkg::pix_t p, int j);
    logic [8:0]     idx;
    logic [TSW-1:0] t2;
    idx = f_idx(p, j);
    t2 = (idx <= 9'd180) ? TSQ[idx[7:0]][TSW-1:0] : '0;
    return PW'(t2) * PW'({p.d, 2'b00});
  endfunction

  // Compare stage of search step j: sign of cos(theta) minus the entry.
  function automatic rhcc_pkg::pix_t f_b(rhcc_pkg::pix_t pi, logic [PW-1:0] rhs, int j);
    rhcc_pkg::pix_t p;
    logic [PW-1:0] lhs;
    logic [1:0]    sa_rk, sb_rk;
    logic          gt, lt, pr;
    p = pi;
    lhs = PW'(p.nsq) << (2 * COS_FRAC_BITS);
    sa_rk = (p.n == 11'd0) ? 2'd1 : (p.n[10] ? 2'd0 : 2'd2);
    sb_rk = p.tsg[1] ? 2'd2 : (p.tsg[0] ? 2'd0 : 2'd1);
    if (sa_rk != sb_rk) begin
      gt = sa_rk > sb_rk;
      lt = sa_rk < sb_rk;
    end else if (sa_rk == 2'd1) begin
      gt = 1'b0;
      lt = 1'b0;
    end else if (sa_rk == 2'd2) begin
      gt = lhs > rhs;
      lt = lhs < rhs;
    end else begin
      gt = lhs < rhs;
      lt = lhs > rhs;
    end
    pr = p.bleg ? !gt : lt;
    if (p.prb && pr) p.cnt = p.cnt + (8'd1 << (NSTEP - 1 - j));
    return p;
  endfunction

  // Output stage: hue from the prefix count, special cases and the mask.
  function automatic rhcc_pkg::pix_t f_fin(rhcc_pkg::pix_t pi, logic [8:0] hmn,
                                           logic [8:0] hmx, logic [6:0] smn,
                                           logic [6:0] smx, logic [6:0] lmn,
                                           logic [6:0] lmx);
    rhcc_pkg::pix_t p;
    logic [8:0] k;
    p = pi;
    if (p.bleg) begin
      p.hue = (p.cnt == 8'd0) ? 9'd0 : 9'(p.cnt) - 9'd1;
    end else begin
      k = (p.cnt > 8'd180) ? 9'd180 : 9'(p.cnt);
      p.hue = (k == 9'd0) ? 9'd0 : 9'd360 - k;
    end
    if (p.hue0) p.hue = 9'd0;
    if (p.gray) p.sq = 7'd0;
    p.in_range = (p.hue >= hmn) && (p.hue <= hmx) && (p.sq >= smn) && (p.sq <= smx)
              && (p.lev >= lmn) && (p.lev <= lmx);
    return p;
  endfunction

  // Pipeline registers and their next values.
  rhcc_pkg::pix_t pl_r   [NST];
  rhcc_pkg::pix_t pl_nxt [NST];
  logic [PW-1:0]  prod_r   [NSTEP];
  logic [PW-1:0]  prod_nxt [NSTEP];
  logic [NST-1:0] v_r;
  logic [NST-1:0] vin;
  logic [NST-1:0] en;

  assign pl_nxt[0] = f_s0(in_tdata);
  assign pl_nxt[1] = f_s1(pl_r[0]);
  assign pl_nxt[NST-1] = f_fin(pl_r[NST-2], hue_min_r, hue_max_r, sat_min_r, sat_max_r,
                               level_min_r, level_max_r);

  genvar j, i;
  generate
    for (j = 0; j < NSTEP; j++) begin : g_step
      assign pl_nxt[2 + 2 * j] = f_a(pl_r[1 + 2 * j], j);
      assign prod_nxt[j]       = f_prod(pl_r[1 + 2 * j], j);
      assign pl_nxt[3 + 2 * j] = f_b(pl_r[2 + 2 * j], prod_r[j], j);

      always_ff @(posedge clk) begin
        if (en[2 + 2 * j] && vin[2 + 2 * j]) prod_r[j] <= prod_nxt[j];
      end
    end

    // A stage moves when it is empty or the stage after it moves.
    for (i = 0; i < NST; i++) begin : g_stage
      if (i == 0) begin : g_first
        assign vin[i] = in_tvalid;
      end else begin : g_rest
        assign vin[i] = v_r[i-1];
      end
      if (i == NST - 1) begin : g_last
        assign en[i] = !v_r[i] || out_tready;
      end else begin : g_mid
        assign en[i] = !v_r[i] || en[i+1];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en[i]) begin
          v_r[i] <= vin[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en[i] && vin[i]) pl_r[i] <= pl_nxt[i];
      end
    end
  endgenerate

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = {pl_r[NST-1].lev, pl_r[NST-1].sq, pl_r[NST-1].hue,
                       pl_r[NST-1].in_range};

endmodule

`default_nettype wire
